>>> rtl/drfp_pkg.sv
// ---------------------------------------------------------------------------
// drfp_pkg: shared types and constants of the dirty rectangle flush planner
// Command and register codes, sequencer states and the operand bundle of
// the shared multiply-add unit.
// ---------------------------------------------------------------------------
package drfp_pkg;

   // Field widths fixed by the interface
   localparam int CMD_W      = 2;
   localparam int CELL_W     = 12;
   localparam int OFFSET_W   = 26;
   localparam int LENGTH_W   = 27;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // Shared multiply-add unit
   localparam int MAC_A_W   = 16;   // widest box coordinate
   localparam int MAC_B_W   = 15;   // line pitch
   localparam int MAC_C_W   = 28;
   localparam int MAC_OUT_W = 32;

   // Pixel coordinates after clamping (screen up to 4096)
   localparam int PIX_W = 12;
   localparam int ROWS_W = 13;
   localparam int ROWLEN_W = 15;

   // Commands
   localparam logic [CMD_W-1:0] CMD_MARK     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MARK_ALL = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COMBINE_THR   = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_X1,
      ST_X2,
      ST_Y1,
      ST_Y2,
      ST_DECIDE,
      ST_LO,
      ST_HI,
      ST_CEMIT,
      ST_ROW
   } state_type;

   // result = min(a * b + c, lim)
   typedef struct packed {
      logic [MAC_A_W-1:0]   a;
      logic [MAC_B_W-1:0]   b;
      logic [MAC_C_W-1:0]   c;
      logic [MAC_OUT_W-1:0] lim;
   } mac_op_type;

endpackage

>>> rtl/drfp_if.sv
// ---------------------------------------------------------------------------
// drfp_if: channel interfaces of the dirty rectangle flush planner
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface drfp_req_if;
   logic                         valid;
   logic                         ready;
   logic [drfp_pkg::CMD_W-1:0]   cmd;
   logic [drfp_pkg::CELL_W-1:0]  cell_x;
   logic [drfp_pkg::CELL_W-1:0]  cell_y;

   modport source (output valid, output cmd, output cell_x, output cell_y, input ready);
   modport sink (input valid, input cmd, input cell_x, input cell_y, output ready);
endinterface

interface drfp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [drfp_pkg::OFFSET_W-1:0]  byte_offset;
   logic [drfp_pkg::LENGTH_W-1:0]  byte_length;
   logic                           last;

   modport source (output valid, output byte_offset, output byte_length, output last,
                   input ready);
   modport sink (input valid, input byte_offset, input byte_length, input last,
                 output ready);
endinterface

interface drfp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [drfp_pkg::CSR_IDX_W-1:0]   index;
   logic [drfp_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/drfp_mac.sv
// ---------------------------------------------------------------------------
// drfp_mac: shared multiply-add unit with upper clamp
// Computes min(a * b + c, lim) for the flush sequencer.
// ---------------------------------------------------------------------------
module drfp_mac (
   input  drfp_pkg::mac_op_type                op,
   output logic [drfp_pkg::MAC_OUT_W-1:0]      result
);

   logic [drfp_pkg::MAC_OUT_W-1:0] sum;

   assign sum = drfp_pkg::MAC_OUT_W'(op.a) * drfp_pkg::MAC_OUT_W'(op.b)
              + drfp_pkg::MAC_OUT_W'(op.c);
   assign result = (sum > op.lim) ? op.lim : sum;

endmodule

>>> rtl/dirty_rect_flush_planner.sv
// ---------------------------------------------------------------------------
// dirty_rect_flush_planner: dirty cell box to framebuffer write ranges
// Tracks a bounding box of dirty character cells; a flush turns it into one
// combined byte range or one range per pixel row, clearing the box once scaled.
// ---------------------------------------------------------------------------
//
//  channel | dir | transaction payload
//  --------+-----+--------------------------------------------------
//  req     | in  | cmd (mark / flush / mark all), cell_x, cell_y
//  rsp     | out | byte_offset, byte_length, last
//  csr     | in  | index, data (register write, always ready)
//
//  Mark, mark all, empty flush and unused commands keep the sequencer idle.
//  Non-empty flush, after its accepting cycle: box scaling and clamping on
//  the shared multiply-add unit (X1, X2, Y1, Y2), a split/combine decision
//  (DECIDE), then LO, HI and CEMIT for a combined range, or ROW once per row
//  for split ranges; req is not ready for the whole flush.
//  A rsp stall holds the sequencer in CEMIT and ROW; the output register frees one slot.
//  Reset (synchronous, active high) restores register defaults, empty box.
// ---------------------------------------------------------------------------
module dirty_rect_flush_planner #(
   parameter int MAX_SPLIT_ROWS = 64,
   parameter int COORD_BITS     = 12
) (
   input logic          clock,
   input logic          reset,
   drfp_req_if.sink     req,
   drfp_rsp_if.source   rsp,
   drfp_csr_if.sink     csr
);

   localparam logic [COORD_BITS-1:0] COORD_ONES = '1;

   // ---------------- configuration registers ----------------
   logic [5:0]  cell_width_ff;
   logic [6:0]  cell_height_ff;
   logic [12:0] screen_width_ff;
   logic [12:0] screen_height_ff;
   logic [14:0] line_pitch_ff;
   logic [11:0] combine_thr_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff    <= 6'd8;
         cell_height_ff   <= 7'd16;
         screen_width_ff  <= 13'd1024;
         screen_height_ff <= 13'd768;
         line_pitch_ff    <= 15'd4096;
         combine_thr_ff   <= 12'd424;
      end else if (csr.valid) begin
         unique case (csr.index)
            drfp_pkg::CSR_CELL_WIDTH:    cell_width_ff    <= csr.data[5:0];
            drfp_pkg::CSR_CELL_HEIGHT:   cell_height_ff   <= csr.data[6:0];
            drfp_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr.data[12:0];
            drfp_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr.data[12:0];
            drfp_pkg::CSR_LINE_PITCH:    line_pitch_ff    <= csr.data[14:0];
            drfp_pkg::CSR_COMBINE_THR:   combine_thr_ff   <= csr.data[11:0];
            default: ;
         endcase
      end
   end

   // Saturated views of the registers
   logic [5:0]                 cw;
   logic [6:0]                 ch;
   logic [drfp_pkg::PIX_W-1:0] sw_max;   // screen width - 1
   logic [drfp_pkg::PIX_W-1:0] sh_max;   // screen height - 1
   logic [14:0]                pitch;

   always_comb begin
      cw = (cell_width_ff == '0) ? 6'd1 : cell_width_ff;
      ch = (cell_height_ff == '0) ? 7'd1 : cell_height_ff;
      if (screen_width_ff == '0)
         sw_max = '0;
      else if (screen_width_ff > 13'd4096)
         sw_max = '1;
      else
         sw_max = drfp_pkg::PIX_W'(screen_width_ff - 13'd1);
      if (screen_height_ff == '0)
         sh_max = '0;
      else if (screen_height_ff > 13'd4096)
         sh_max = '1;
      else
         sh_max = drfp_pkg::PIX_W'(screen_height_ff - 13'd1);
      if (line_pitch_ff < 15'd4)
         pitch = 15'd4;
      else if (line_pitch_ff > 15'd16384)
         pitch = 15'd16384;
      else
         pitch = line_pitch_ff;
   end

   // ---------------- state ----------------
   drfp_pkg::state_type state_ff, state_in;

   logic                  box_valid_ff;
   logic [COORD_BITS-1:0] box_left_ff, box_right_ff, box_top_ff, box_bottom_ff;

   // clamped pixel box
   logic [drfp_pkg::PIX_W-1:0]    x1_ff, x2_ff, y1_ff, y2_ff;
   logic [drfp_pkg::PIX_W-1:0]    y_ff;          // current split row
   logic [drfp_pkg::ROWLEN_W-1:0] row_len_ff;    // bytes per split row
   logic [drfp_pkg::LENGTH_W-1:0] lo_ff, hi_ff;  // combined range bounds

   // output register
   logic                          rsp_valid_ff;
   logic [drfp_pkg::OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [drfp_pkg::LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_load;

   logic                          slot_free;
   logic                          req_accept;
   logic [COORD_BITS-1:0]         cx, cy;

   assign slot_free  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;
   assign cx = COORD_BITS'(req.cell_x);
   assign cy = COORD_BITS'(req.cell_y);

   // ---------------- shared multiply-add ----------------
   drfp_pkg::mac_op_type              mac_op;
   logic [drfp_pkg::MAC_OUT_W-1:0]    mac_result;

   drfp_mac u_mac (
      .op     (mac_op),
      .result (mac_result)
   );

   // split/combine decision terms, valid once x1, x2, y1 and y2 are loaded
   logic [drfp_pkg::PIX_W-1:0]  x_span;
   logic [drfp_pkg::ROWS_W-1:0] rows;
   logic                        combine;

   assign x_span  = x2_ff - x1_ff;
   assign rows    = drfp_pkg::ROWS_W'(y2_ff) - drfp_pkg::ROWS_W'(y1_ff) + 1'b1;
   assign combine = (x_span > combine_thr_ff) ||
                    (rows > drfp_pkg::ROWS_W'(MAX_SPLIT_ROWS));

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drfp_pkg::ST_IDLE: begin
            if (req_accept && req.cmd == drfp_pkg::CMD_FLUSH && box_valid_ff)
               state_in = drfp_pkg::ST_X1;
         end
         drfp_pkg::ST_X1:     state_in = drfp_pkg::ST_X2;
         drfp_pkg::ST_X2:     state_in = drfp_pkg::ST_Y1;
         drfp_pkg::ST_Y1:     state_in = drfp_pkg::ST_Y2;
         drfp_pkg::ST_Y2:     state_in = drfp_pkg::ST_DECIDE;
         drfp_pkg::ST_DECIDE: state_in = combine ? drfp_pkg::ST_LO : drfp_pkg::ST_ROW;
         drfp_pkg::ST_LO:     state_in = drfp_pkg::ST_HI;
         drfp_pkg::ST_HI:     state_in = drfp_pkg::ST_CEMIT;
         drfp_pkg::ST_CEMIT: begin
            if (slot_free)
               state_in = drfp_pkg::ST_IDLE;
         end
         drfp_pkg::ST_ROW: begin
            if (slot_free && y_ff == y2_ff)
               state_in = drfp_pkg::ST_IDLE;
         end
         default: state_in = drfp_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req.ready     = 1'b0;
      mac_op        = '0;
      mac_op.lim    = '1;
      rsp_load      = 1'b0;
      rsp_offset_in = drfp_pkg::OFFSET_W'(lo_ff);
      rsp_length_in = hi_ff - lo_ff;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         drfp_pkg::ST_IDLE: req.ready = 1'b1;
         drfp_pkg::ST_X1: begin
            mac_op.a   = drfp_pkg::MAC_A_W'(box_left_ff);
            mac_op.b   = drfp_pkg::MAC_B_W'(cw);
            mac_op.lim = drfp_pkg::MAC_OUT_W'(sw_max);
         end
         drfp_pkg::ST_X2: begin
            mac_op.a   = drfp_pkg::MAC_A_W'(box_right_ff);
            mac_op.b   = drfp_pkg::MAC_B_W'(cw);
            mac_op.c   = drfp_pkg::MAC_C_W'(cw - 6'd1);
            mac_op.lim = drfp_pkg::MAC_OUT_W'(sw_max);
         end
         drfp_pkg::ST_Y1: begin
            mac_op.a   = drfp_pkg::MAC_A_W'(box_top_ff);
            mac_op.b   = drfp_pkg::MAC_B_W'(ch);
            mac_op.lim = drfp_pkg::MAC_OUT_W'(sh_max);
         end
         drfp_pkg::ST_Y2: begin
            mac_op.a   = drfp_pkg::MAC_A_W'(box_bottom_ff);
            mac_op.b   = drfp_pkg::MAC_B_W'(ch);
            mac_op.c   = drfp_pkg::MAC_C_W'(ch - 7'd1);
            mac_op.lim = drfp_pkg::MAC_OUT_W'(sh_max);
         end
         drfp_pkg::ST_DECIDE: ;
         drfp_pkg::ST_LO: begin
            mac_op.a = drfp_pkg::MAC_A_W'(y1_ff);
            mac_op.b = pitch;
            mac_op.c = drfp_pkg::MAC_C_W'(x1_ff) << 2;
         end
         drfp_pkg::ST_HI: begin
            mac_op.a = drfp_pkg::MAC_A_W'(y2_ff);
            mac_op.b = pitch;
            mac_op.c = (drfp_pkg::MAC_C_W'(x2_ff) << 2) + drfp_pkg::MAC_C_W'(4);
         end
         drfp_pkg::ST_CEMIT: rsp_load = slot_free;
         drfp_pkg::ST_ROW: begin
            mac_op.a      = drfp_pkg::MAC_A_W'(y_ff);
            mac_op.b      = pitch;
            mac_op.c      = drfp_pkg::MAC_C_W'(x1_ff) << 2;
            rsp_load      = slot_free;
            rsp_offset_in = mac_result[drfp_pkg::OFFSET_W-1:0];
            rsp_length_in = drfp_pkg::LENGTH_W'(row_len_ff);
            rsp_last_in   = (y_ff == y2_ff);
         end
         default: ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= drfp_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Dirty box: marks in idle, cleared once the flush has scaled it
   always_ff @(posedge clock) begin
      if (reset || state_ff == drfp_pkg::ST_Y2) begin
         box_valid_ff  <= 1'b0;
         box_left_ff   <= COORD_ONES;
         box_top_ff    <= COORD_ONES;
         box_right_ff  <= '0;
         box_bottom_ff <= '0;
      end else if (req_accept) begin
         case (req.cmd)
            drfp_pkg::CMD_MARK: begin
               box_valid_ff <= 1'b1;
               if (!box_valid_ff) begin
                  box_left_ff   <= cx;
                  box_right_ff  <= cx;
                  box_top_ff    <= cy;
                  box_bottom_ff <= cy;
               end else begin
                  if (cx < box_left_ff)   box_left_ff   <= cx;
                  if (cx > box_right_ff)  box_right_ff  <= cx;
                  if (cy < box_top_ff)    box_top_ff    <= cy;
                  if (cy > box_bottom_ff) box_bottom_ff <= cy;
               end
            end
            drfp_pkg::CMD_MARK_ALL: begin
               box_valid_ff  <= 1'b1;
               box_left_ff   <= '0;
               box_top_ff    <= '0;
               box_right_ff  <= COORD_ONES;
               box_bottom_ff <= COORD_ONES;
            end
            default: ;
         endcase
      end
   end

   // Flush datapath, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         drfp_pkg::ST_X1: x1_ff <= mac_result[drfp_pkg::PIX_W-1:0];
         drfp_pkg::ST_X2: x2_ff <= mac_result[drfp_pkg::PIX_W-1:0];
         drfp_pkg::ST_Y1: y1_ff <= mac_result[drfp_pkg::PIX_W-1:0];
         drfp_pkg::ST_Y2: y2_ff <= mac_result[drfp_pkg::PIX_W-1:0];
         drfp_pkg::ST_LO: lo_ff <= mac_result[drfp_pkg::LENGTH_W-1:0];
         drfp_pkg::ST_HI: hi_ff <= mac_result[drfp_pkg::LENGTH_W-1:0];
         drfp_pkg::ST_ROW: begin
            if (slot_free)
               y_ff <= y_ff + 1'b1;
         end
         default: ;
      endcase
      if (state_ff == drfp_pkg::ST_DECIDE) begin
         y_ff       <= y1_ff;
         row_len_ff <= (drfp_pkg::ROWLEN_W'(x_span) << 2) + drfp_pkg::ROWLEN_W'(4);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp.ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_offset_ff <= rsp_offset_in;
         rsp_length_ff <= rsp_length_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.byte_offset = rsp_offset_ff;
   assign rsp.byte_length = rsp_length_ff;
   assign rsp.last        = rsp_last_ff;

   // ---------------- assertions ----------------
`ifndef NO_ASSERTIONS
   // A dirty box never runs backward
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      box_valid_ff |-> (box_left_ff <= box_right_ff && box_top_ff <= box_bottom_ff))
      else $error("dirty box inverted");

   // Split rows stay within the clamped box
   a_row_in_box: assert property (@(posedge clock) disable iff (reset)
      state_ff == drfp_pkg::ST_ROW |-> (y_ff >= y1_ff && y_ff <= y2_ff && x1_ff <= x2_ff))
      else $error("split row outside box");

   // The final range of a flush ends it with the box already cleared
   a_last_ends_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == drfp_pkg::ST_IDLE && !box_valid_ff))
      else $error("flush did not end on last range");
`endif

endmodule
